// ===== design/sab_pkg.sv =====
`default_nettype none
package sab_pkg;

  localparam int CANVAS_WIDTH_DEF  = 640;
  localparam int CANVAS_HEIGHT_DEF = 480;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_PLACE_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLACE_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR        = 3'd6;

  localparam logic [1:0] KIND_SPRITE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;

  localparam logic [2:0] ST_COPIED      = 3'd0;
  localparam logic [2:0] ST_BLENDED     = 3'd1;
  localparam logic [2:0] ST_TRANSPARENT = 3'd2;
  localparam logic [2:0] ST_CLIPPED     = 3'd3;
  localparam logic [2:0] ST_DONE        = 3'd4;

  localparam logic [7:0] ALPHA_ZERO = 8'd0;
  localparam logic [7:0] ALPHA_FULL = 8'd255;
  localparam logic [7:0] ROUND_HALF = 8'd127;

  typedef struct packed {
    logic signed [11:0] place_x;
    logic signed [11:0] place_y;
    logic [10:0]        window_left;
    logic [10:0]        window_top;
    logic [11:0]        window_width;
    logic [11:0]        window_height;
    logic               mirror;
  } cfg_t;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic       mix;
    logic [2:0] status;
  } map_t;

endpackage
`default_nettype wire

// ===== design/sab_frame_mem.sv =====
`default_nettype none
module sab_frame_mem #(
  parameter int DEPTH = sab_pkg::CANVAS_WIDTH_DEF * sab_pkg::CANVAS_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [23:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [23:0]   rdata_r
);

  logic [23:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/sab_map.sv =====
`default_nettype none
module sab_map #(
  parameter int CANVAS_WIDTH  = sab_pkg::CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = sab_pkg::CANVAS_HEIGHT_DEF,
  parameter int AW            = $clog2(CANVAS_WIDTH * CANVAS_HEIGHT)
) (
  input  wire logic               clk,
  input  wire sab_pkg::cfg_t      cfg,
  input  wire logic [1:0]         kind,
  input  wire logic signed [11:0] column,
  input  wire logic signed [11:0] row,
  input  wire logic [7:0]         alpha,
  output sab_pkg::map_t           map_r,
  output logic [AW-1:0]           addr_r
);

  logic signed [12:0] ox;
  logic signed [12:0] oy;
  logic               win_ok;
  logic [12:0]        mx;
  logic signed [13:0] sx;
  logic signed [13:0] sy;
  logic signed [13:0] x_nxt;
  logic signed [13:0] y_nxt;
  logic signed [13:0] x_r;
  logic signed [13:0] y_r;
  logic               win_ok_r;
  logic               on_canvas;
  sab_pkg::map_t      map_nxt;
  logic [AW-1:0]      addr_nxt;

  always_comb begin
    ox = {column[11], column} - $signed({2'b00, cfg.window_left});
    oy = {row[11], row} - $signed({2'b00, cfg.window_top});
    win_ok = !ox[12] && (ox[11:0] < cfg.window_width) &&
             !oy[12] && (oy[11:0] < cfg.window_height);
    mx = cfg.mirror ? (13'(cfg.window_width) - 13'd1 - 13'(ox)) : 13'(ox);
    sx = 14'(cfg.place_x) + $signed({1'b0, mx});
    sy = 14'(cfg.place_y) + $signed({oy[12], oy});
    if (kind == sab_pkg::KIND_SPRITE) begin
      x_nxt = sx;
      y_nxt = sy;
    end else begin
      x_nxt = 14'(column);
      y_nxt = 14'(row);
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    win_ok_r <= win_ok;
  end

  always_comb begin
    on_canvas = !x_r[13] && (x_r < $signed(14'(CANVAS_WIDTH))) &&
                !y_r[13] && (y_r < $signed(14'(CANVAS_HEIGHT)));
    addr_nxt = AW'(y_r[10:0]) * AW'(CANVAS_WIDTH) + AW'(x_r[10:0]);
    map_nxt = '{rd: 1'b0, wr: 1'b0, mix: 1'b0, status: sab_pkg::ST_CLIPPED};
    case (kind)
      sab_pkg::KIND_SPRITE: begin
        if (win_ok_r && on_canvas) begin
          if (alpha == sab_pkg::ALPHA_ZERO) begin
            map_nxt.status = sab_pkg::ST_TRANSPARENT;
          end else if (alpha == sab_pkg::ALPHA_FULL) begin
            map_nxt.wr     = 1'b1;
            map_nxt.status = sab_pkg::ST_COPIED;
          end else begin
            map_nxt.rd     = 1'b1;
            map_nxt.wr     = 1'b1;
            map_nxt.mix    = 1'b1;
            map_nxt.status = sab_pkg::ST_BLENDED;
          end
        end
      end
      sab_pkg::KIND_READ: begin
        if (on_canvas) begin
          map_nxt.rd     = 1'b1;
          map_nxt.status = sab_pkg::ST_DONE;
        end
      end
      sab_pkg::KIND_WRITE: begin
        if (on_canvas) begin
          map_nxt.wr     = 1'b1;
          map_nxt.status = sab_pkg::ST_DONE;
        end
      end
      default: begin
        map_nxt.status = sab_pkg::ST_CLIPPED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    map_r  <= map_nxt;
    addr_r <= addr_nxt;
  end

endmodule
`default_nettype wire

// ===== design/sab_blend.sv =====
`default_nettype none
module sab_blend (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [23:0] src,
  input  wire logic [23:0] dst,
  input  wire logic [7:0]  alpha,
  output logic      [23:0] mixed
);

  logic [15:0] sum_nxt [3];
  logic [15:0] sum_r   [3];
  logic [16:0] q       [3];
  logic [7:0]  inv;

  always_comb begin
    inv = sab_pkg::ALPHA_FULL - alpha;
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = 16'(src[8*i +: 8]) * 16'(alpha) + 16'(dst[8*i +: 8]) * 16'(inv) +
                   16'(sab_pkg::ROUND_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= sum_nxt[i];
      end
    end
  end

  // divide by 255: (n + 1 + n/256) / 256, exact below 65535
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = 17'(sum_r[i]) + 17'd1 + 17'(sum_r[i][15:8]);
      mixed[8*i +: 8] = q[i][15:8];
    end
  end

endmodule
`default_nettype wire

// ===== design/sprite_alpha_blitter.sv =====
`default_nettype none
// channel   dir  ports                                          handshake
// request   in   in_kind in_column in_row in_pixel              start & !busy
// result    out  out_read_data out_status                       out_valid, 1 cycle
// config    in   cfg_index cfg_data                             cfg_we
//
// One request at a time: accept, map, address, memory read, mix, write back.
// out_valid pulses as the mix state is left and busy drops with it, so a
// request is taken only once the last one's read-modify-write on the frame
// store is done. Reset clears only state, config, write-back and out_valid
// registers; the store holds garbage until written. The receiver cannot stall.
module sprite_alpha_blitter #(
  parameter int CANVAS_WIDTH  = sab_pkg::CANVAS_WIDTH_DEF,
  parameter int CANVAS_HEIGHT = sab_pkg::CANVAS_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_kind,
  input  wire logic signed [11:0]             in_column,
  input  wire logic signed [11:0]             in_row,
  input  wire logic [31:0]                    in_pixel,
  output logic                                out_valid,
  output logic [23:0]                         out_read_data,
  output logic [2:0]                          out_status,
  input  wire logic                           cfg_we,
  input  wire logic [sab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sab_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAP  = 5'b00010,
    S_ADDR = 5'b00100,
    S_READ = 5'b01000,
    S_MIX  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  sab_pkg::cfg_t      cfg_r;
  logic [1:0]         kind_r;
  logic signed [11:0] column_r;
  logic signed [11:0] row_r;
  logic [31:0]        pixel_r;
  sab_pkg::map_t      map;
  logic [AW-1:0]      addr;
  logic [23:0]        rdata;
  logic [23:0]        mixed;
  logic               mem_we;
  logic               mem_re;
  logic [23:0]        wdata;
  logic               out_valid_r;
  logic [23:0]        out_read_data_r;
  logic [2:0]         out_status_r;
  logic               wb_r;
  logic               wb_mix_r;
  logic [AW-1:0]      wb_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sab_pkg::CFG_PLACE_X:       cfg_r.place_x       <= cfg_data;
        sab_pkg::CFG_PLACE_Y:       cfg_r.place_y       <= cfg_data;
        sab_pkg::CFG_WINDOW_LEFT:   cfg_r.window_left   <= cfg_data[10:0];
        sab_pkg::CFG_WINDOW_TOP:    cfg_r.window_top    <= cfg_data[10:0];
        sab_pkg::CFG_WINDOW_WIDTH:  cfg_r.window_width  <= cfg_data;
        sab_pkg::CFG_WINDOW_HEIGHT: cfg_r.window_height <= cfg_data;
        sab_pkg::CFG_MIRROR:        cfg_r.mirror        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_MAP;
      S_MAP:  state_nxt = S_ADDR;
      S_ADDR: state_nxt = S_READ;
      S_READ: state_nxt = S_MIX;
      S_MIX:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      kind_r   <= in_kind;
      column_r <= in_column;
      row_r    <= in_row;
      pixel_r  <= in_pixel;
    end
  end

  assign busy = (state_r != S_IDLE);

  sab_map #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT),
    .AW           (AW)
  ) u_map (
    .clk   (clk),
    .cfg   (cfg_r),
    .kind  (kind_r),
    .column(column_r),
    .row   (row_r),
    .alpha (pixel_r[31:24]),
    .map_r (map),
    .addr_r(addr)
  );

  sab_blend u_blend (
    .clk  (clk),
    .en   (state_r == S_MIX),
    .src  (pixel_r[23:0]),
    .dst  (rdata),
    .alpha(pixel_r[31:24]),
    .mixed(mixed)
  );

  // write back in the cycle after the mix; the next request cannot reach the
  // store before then
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= 1'b0;
    end else begin
      wb_r <= (state_r == S_MIX) && map.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MIX) begin
      wb_mix_r  <= map.mix;
      wb_addr_r <= addr;
    end
  end

  assign mem_re = (state_r == S_READ) && map.rd;
  assign mem_we = wb_r;
  assign wdata  = wb_mix_r ? mixed : pixel_r[23:0];

  sab_frame_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (wb_addr_r),
    .wdata  (wdata),
    .re     (mem_re),
    .raddr  (addr),
    .rdata_r(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_MIX);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MIX) begin
      out_status_r    <= map.status;
      out_read_data_r <= (map.rd && !map.mix) ? rdata : 24'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_read_data_r;

endmodule
`default_nettype wire

// ===== design/sab_checker.sv =====
`default_nettype none
module sab_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [23:0] out_read_data,
  input wire logic [2:0]  out_status
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result without a request in flight");

  a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sab_pkg::ST_DONE |-> out_read_data == 24'd0)
    else $error("read data set on a non-access result");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= sab_pkg::ST_DONE)
    else $error("status code out of range");

endmodule

bind sprite_alpha_blitter sab_checker u_sab_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_read_data(out_read_data),
  .out_status   (out_status)
);
`default_nettype wire

// ===== tb/sv/sprite_alpha_blitter_compare.sv =====
module sprite_alpha_blitter_compare
  import sab_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic                    busy,
  input  wire logic [1:0]              in_kind,
  input  wire logic signed [11:0]      in_column,
  input  wire logic signed [11:0]      in_row,
  input  wire logic [31:0]             in_pixel,
  input  wire logic                    out_valid,
  input  wire logic [23:0]             out_read_data,
  input  wire logic [2:0]              out_status,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  output int                           outstanding,
  output int                           mismatch_count
);

  localparam int CANVAS_W = CANVAS_WIDTH_DEF;
  localparam int CANVAS_H = CANVAS_HEIGHT_DEF;

  typedef struct packed {
    logic [23:0] read_data;
    logic [2:0]  status;
  } outcome_t;

  logic [23:0] canvas_copy [0:CANVAS_W*CANVAS_H-1];
  outcome_t    awaited_outcomes[$];
  outcome_t    due;
  int          place_x;
  int          place_y;
  int          window_left;
  int          window_top;
  int          window_width;
  int          window_height;
  logic        mirror;
  int          errors = 0;

  assign mismatch_count = errors;

  function automatic bit on_canvas(input int x, input int y);
    return x >= 0 && x < CANVAS_W && y >= 0 && y < CANVAS_H;
  endfunction

  function automatic logic [7:0] mix_channel(input int unsigned src, input int unsigned dst,
                                             input int unsigned a);
    return 8'((src * a + dst * (ALPHA_FULL - a) + ROUND_HALF) / ALPHA_FULL);
  endfunction

  function automatic outcome_t composite(input logic [1:0] kind, input int col, input int row,
                                         input logic [31:0] pixel);
    outcome_t    res;
    int          ox;
    int          oy;
    int          x;
    int          y;
    int          idx;
    logic [7:0]  a;
    logic [23:0] dst;
    res.read_data = '0;
    res.status    = ST_CLIPPED;
    a             = pixel[31:24];
    case (kind)
      KIND_SPRITE: begin
        ox = col - window_left;
        oy = row - window_top;
        if (ox >= 0 && ox < window_width && oy >= 0 && oy < window_height) begin
          x = place_x + (mirror ? window_width - 1 - ox : ox);
          y = place_y + oy;
          if (on_canvas(x, y)) begin
            idx = y * CANVAS_W + x;
            if (a == ALPHA_ZERO) begin
              res.status = ST_TRANSPARENT;
            end else if (a == ALPHA_FULL) begin
              canvas_copy[idx] = pixel[23:0];
              res.status       = ST_COPIED;
            end else begin
              dst              = canvas_copy[idx];
              canvas_copy[idx] = {mix_channel(pixel[23:16], dst[23:16], a),
                                  mix_channel(pixel[15:8], dst[15:8], a),
                                  mix_channel(pixel[7:0], dst[7:0], a)};
              res.status       = ST_BLENDED;
            end
          end
        end
      end
      KIND_READ: begin
        if (on_canvas(col, row)) begin
          res.read_data = canvas_copy[row * CANVAS_W + col];
          res.status    = ST_DONE;
        end
      end
      KIND_WRITE: begin
        if (on_canvas(col, row)) begin
          canvas_copy[row * CANVAS_W + col] = pixel[23:0];
          res.status                        = ST_DONE;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      place_x       = 0;
      place_y       = 0;
      window_left   = 0;
      window_top    = 0;
      window_width  = 0;
      window_height = 0;
      mirror        = 1'b0;
      awaited_outcomes.delete();
      outstanding <= 0;
    end else begin
      if (out_valid) begin
        if (awaited_outcomes.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending, read_data %h status %0d",
                   $time, out_read_data, out_status);
        end else begin
          due = awaited_outcomes.pop_front();
          if (out_status !== due.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, due.status, out_status);
          end
          if (out_read_data !== due.read_data) begin
            errors++;
            $display("%0t: read_data expected %h, got %h", $time, due.read_data,
                     out_read_data);
          end
        end
      end
      if (start && !busy) begin
        awaited_outcomes.push_back(composite(in_kind, in_column, in_row, in_pixel));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PLACE_X:       place_x = $signed(cfg_data);
          CFG_PLACE_Y:       place_y = $signed(cfg_data);
          CFG_WINDOW_LEFT:   window_left = cfg_data[10:0];
          CFG_WINDOW_TOP:    window_top = cfg_data[10:0];
          CFG_WINDOW_WIDTH:  window_width = cfg_data;
          CFG_WINDOW_HEIGHT: window_height = cfg_data;
          CFG_MIRROR:        mirror = cfg_data[0];
          default: ;
        endcase
      end
      outstanding <= awaited_outcomes.size();
    end
  end

endmodule

// ===== tb/sv/sprite_alpha_blitter_test.sv =====
module sprite_alpha_blitter_test;
  import sab_pkg::*;

  localparam int CANVAS_W    = CANVAS_WIDTH_DEF;
  localparam int CANVAS_H    = CANVAS_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LAYOUTS     = 16;
  localparam int PER_LAYOUT  = 95;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_kind = KIND_SPRITE;
  logic signed [11:0]    in_column = '0;
  logic signed [11:0]    in_row = '0;
  logic [31:0]           in_pixel = '0;
  logic                  out_valid;
  logic [23:0]           out_read_data;
  logic [2:0]            out_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PLACE_X;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    outstanding;
  int                    mismatch_count;
  int                    cycle_count = 0;

  bit written_map [0:CANVAS_W*CANVAS_H-1];
  int written_list[$];
  int place_x = 0;
  int place_y = 0;
  int win_left = 0;
  int win_top = 0;
  int win_width = 0;
  int win_height = 0;
  bit mirror_on = 1'b0;
  int idle_pct = 0;
  int n_sprite = 0;
  int n_read = 0;
  int n_write = 0;
  int n_unused = 0;
  int n_layouts = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sprite_alpha_blitter i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_column     (in_column),
    .in_row        (in_row),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  sprite_alpha_blitter_compare i_compare (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .outstanding    (outstanding),
    .mismatch_count (mismatch_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bit on_canvas(input int x, input int y);
    return x >= 0 && x < CANVAS_W && y >= 0 && y < CANVAS_H;
  endfunction

  function automatic bit sprite_lands(input int col, input int row, output int x,
                                      output int y);
    int ox;
    int oy;
    ox = col - win_left;
    oy = row - win_top;
    x  = place_x + (mirror_on ? win_width - 1 - ox : ox);
    y  = place_y + oy;
    return ox >= 0 && ox < win_width && oy >= 0 && oy < win_height && on_canvas(x, y);
  endfunction

  task automatic mark_written(input int x, input int y);
    int idx;
    idx = y * CANVAS_W + x;
    if (!written_map[idx]) begin
      written_map[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_layout(input int px, input int py, input int wl, input int wt,
                            input int ww, input int wh, input bit mir);
    drain();
    place_x    = px;
    place_y    = py;
    win_left   = wl;
    win_top    = wt;
    win_width  = ww;
    win_height = wh;
    mirror_on  = mir;
    put_reg(CFG_PLACE_X, px);
    put_reg(CFG_PLACE_Y, py);
    put_reg(CFG_WINDOW_LEFT, wl);
    put_reg(CFG_WINDOW_TOP, wt);
    put_reg(CFG_WINDOW_WIDTH, ww);
    put_reg(CFG_WINDOW_HEIGHT, wh);
    put_reg(CFG_MIRROR, mir);
    cfg_we <= 1'b0;
    n_layouts++;
  endtask

  // keep every read and blend on a pixel that has already been stored
  task automatic issue(input logic [1:0] kind, input logic signed [11:0] col,
                       input logic signed [11:0] row, input logic [31:0] pixel);
    int x;
    int y;
    int idx;
    case (kind)
      KIND_SPRITE: begin
        n_sprite++;
        if (sprite_lands(col, row, x, y) && pixel[31:24] != ALPHA_ZERO) begin
          if (!written_map[y * CANVAS_W + x]) pixel[31:24] = ALPHA_FULL;
          mark_written(x, y);
        end
      end
      KIND_READ: begin
        n_read++;
        if (on_canvas(col, row) && !written_map[row * CANVAS_W + col]) begin
          idx = written_list[$urandom_range(written_list.size() - 1)];
          col = 12'(idx % CANVAS_W);
          row = 12'(idx / CANVAS_W);
        end
      end
      KIND_WRITE: begin
        n_write++;
        if (on_canvas(col, row)) mark_written(col, row);
      end
      default: n_unused++;
    endcase
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start     <= 1'b1;
    in_kind   <= kind;
    in_column <= col;
    in_row    <= row;
    in_pixel  <= pixel;
    do @(posedge clk); while (busy);
  endtask

  task automatic random_layout();
    int pick;
    int px;
    int py;
    int wl;
    int wt;
    int ww;
    int wh;
    pick = $urandom_range(9);
    px   = int'($urandom_range(56)) - 8;
    py   = int'($urandom_range(56)) - 8;
    wl   = $urandom_range(2000);
    wt   = $urandom_range(2000);
    ww   = $urandom_range(1, 12);
    wh   = $urandom_range(1, 12);
    case (pick)
      0: begin
        px = CANVAS_W - 1 - int'($urandom_range(10));
        py = CANVAS_H - 1 - int'($urandom_range(10));
      end
      1: begin
        px = 2047;
        py = -2048;
      end
      2: begin
        wl = 0;
        ww = 2048;
        px = int'($urandom_range(8)) - 2040;
      end
      3: begin
        if ($urandom_range(1)) ww = 0;
        else wh = 0;
      end
      default: ;
    endcase
    set_layout(px, py, wl, wt, ww, wh, $urandom_range(1));
  endtask

  task automatic random_request();
    int         sel;
    int         ox;
    int         oy;
    int         span_x;
    int         span_y;
    int         idx;
    logic [7:0] alpha;
    sel    = $urandom_range(99);
    span_x = win_width < 24 ? win_width : 24;
    span_y = win_height < 24 ? win_height : 24;
    if (sel < 8) begin
      issue(2'($urandom_range(3)), 12'($urandom()), 12'($urandom()), $urandom());
    end else if (sel < 70) begin
      if ($urandom_range(3) == 0) ox = win_width - 2 + int'($urandom_range(3));
      else ox = int'($urandom_range(span_x + 3)) - 2;
      if ($urandom_range(3) == 0) oy = win_height - 2 + int'($urandom_range(3));
      else oy = int'($urandom_range(span_y + 3)) - 2;
      case ($urandom_range(9))
        0, 1:    alpha = ALPHA_ZERO;
        2, 3, 4: alpha = ALPHA_FULL;
        default: alpha = 8'($urandom_range(1, 254));
      endcase
      issue(KIND_SPRITE, 12'(win_left + ox), 12'(win_top + oy), {alpha, 24'($urandom())});
    end else if (sel < 85) begin
      if ($urandom_range(9) == 0) begin
        issue(KIND_READ, 12'($urandom()), 12'($urandom()), $urandom());
      end else begin
        idx = written_list[$urandom_range(written_list.size() - 1)];
        issue(KIND_READ, 12'(idx % CANVAS_W), 12'(idx / CANVAS_W), $urandom());
      end
    end else begin
      if ($urandom_range(3) == 0) begin
        issue(KIND_WRITE, 12'($urandom()), 12'($urandom()), $urandom());
      end else begin
        issue(KIND_WRITE, 12'(place_x + int'($urandom_range(span_x))),
              12'(place_y + int'($urandom_range(span_y))), $urandom());
      end
    end
  endtask

  initial begin
    int layout;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: empty window, so every sprite pixel clips
    issue(KIND_SPRITE, 12'sd0, 12'sd0, 32'hFF00FF00);
    issue(KIND_WRITE, 12'sd0, 12'sd0, 32'h00A0B0C0);
    issue(KIND_WRITE, 12'sd639, 12'sd479, 32'hFF123456);
    issue(KIND_WRITE, -12'sd1, 12'sd0, 32'hFFFFFFFF);
    issue(KIND_WRITE, 12'sd640, 12'sd5, 32'h12345678);
    issue(KIND_READ, 12'sd0, 12'sd0, 32'h0);
    issue(KIND_READ, 12'sd639, 12'sd479, 32'hFFFFFFFF);
    issue(KIND_READ, 12'h800, 12'h7FF, 32'h0);
    issue(KIND_READ, 12'sd0, 12'sd480, 32'h0);
    issue(KIND_UNUSED, 12'h7FF, 12'h800, 32'hFFFFFFFF);

    set_layout(0, 0, 100, 200, 4, 3, 1'b0);
    issue(KIND_SPRITE, 12'sd100, 12'sd200, 32'hFF112233);
    issue(KIND_SPRITE, 12'sd101, 12'sd200, 32'h00FFFFFF);
    issue(KIND_SPRITE, 12'sd100, 12'sd200, 32'h80FFFFFF);
    issue(KIND_SPRITE, 12'sd100, 12'sd200, 32'h01000000);
    issue(KIND_SPRITE, 12'sd100, 12'sd200, 32'hFEABCDEF);
    issue(KIND_SPRITE, 12'sd99, 12'sd200, 32'hFFFFFFFF);
    issue(KIND_SPRITE, 12'sd104, 12'sd200, 32'hFFFFFFFF);
    issue(KIND_SPRITE, 12'sd100, 12'sd203, 32'hFFFFFFFF);
    issue(KIND_SPRITE, 12'sd100, 12'sd199, 32'hFFFFFFFF);
    issue(KIND_READ, 12'sd0, 12'sd0, 32'h0);

    set_layout(-2, 0, 100, 200, 4, 3, 1'b1);
    issue(KIND_SPRITE, 12'sd100, 12'sd200, 32'hFF445566);
    issue(KIND_SPRITE, 12'sd103, 12'sd200, 32'hFF778899);
    issue(KIND_READ, 12'sd1, 12'sd0, 32'h0);

    set_layout(-2048, 2047, 2047, 2047, 4095, 4095, 1'b1);
    issue(KIND_SPRITE, 12'sd2047, 12'sd2047, 32'hFFFFFFFF);
    issue(KIND_SPRITE, 12'h800, 12'sd2047, 32'h80FFFFFF);

    set_layout(2047, -2048, 0, 0, 2048, 2048, 1'b0);
    issue(KIND_SPRITE, 12'sd0, 12'sd0, 32'hFF000000);

    for (layout = 0; layout < LAYOUTS; layout++) begin
      random_layout();
      case (layout % 4)
        1:       idle_pct = 82;
        3:       idle_pct = 18;
        default: idle_pct = 0;
      endcase
      repeat (PER_LAYOUT) random_request();
    end
    drain();

    $display("Covered %0d sprite pixels, %0d reads, %0d solid writes and %0d unused-kind",
             n_sprite, n_read, n_write, n_unused);
    $display("requests across %0d window settings, %0d canvas pixels touched",
             n_layouts, written_list.size());
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
